[rtl/pltm_pkg.sv]
`timescale 1ns / 1ps

package pltm_pkg;

  localparam int TABLE_ENTRIES   = 2;
  localparam int BATT_THRESHOLDS = 2;
  localparam int AC_THRESHOLDS   = 2;
  // thresholds actually checked per table
  localparam int NB = (BATT_THRESHOLDS > TABLE_ENTRIES) ? TABLE_ENTRIES : BATT_THRESHOLDS;
  localparam int NA = (AC_THRESHOLDS > TABLE_ENTRIES) ? TABLE_ENTRIES : AC_THRESHOLDS;

  localparam int BATT_ROWS = 2;
  localparam int AC_ROWS   = 4;
  localparam int CNT_W     = 7;
  localparam int CUR_W     = 17;
  localparam int REASON_W  = 4;
  localparam int MV_W      = 12;
  localparam int LIMIT_W   = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_ADAPTER = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_BATT_SEL = 1'b0;

  typedef enum logic [1:0] {
    ADP_UNKNOWN = 2'd0,
    ADP_45W     = 2'd1,
    ADP_65W     = 2'd2,
    ADP_90W     = 2'd3
  } adapter_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] hi;
    logic signed [CUR_W-1:0] lo;
    logic [CNT_W-1:0]        hi_cnt;
    logic [CNT_W-1:0]        lo_cnt;
  } limit_t;

  typedef struct packed {
    logic             trig;
    logic [CNT_W-1:0] cnt;
  } ent_t;

  typedef ent_t [TABLE_ENTRIES-1:0] row_t;

  typedef struct packed {
    ent_t ent;
    logic set;
    logic clr;
  } watch_t;

  typedef struct packed {
    logic                   mode;
    logic signed [15:0]     batt;
    logic signed [15:0]     chg;
    logic                   ac;
    logic                   apoff;
    adapter_t               adapter;
    logic                   sel;
  } s1_req_t;

  typedef struct packed {
    logic                bwe;
    logic                awe;
    logic [REASON_W-1:0] reason;
    row_t                brow;
    row_t                arow;
  } upd_t;

  localparam logic [MV_W-1:0] ID_LO [4] = '{12'd0, 12'd434, 12'd561, 12'd725};
  localparam logic [MV_W-1:0] ID_HI [4] = '{12'd0, 12'd554, 12'd717, 12'd925};
  localparam logic [LIMIT_W-1:0] INPUT_LIMIT [4] =
    '{13'h0800, 13'h0800, 13'h0c00, 13'h1100};

  localparam limit_t BATT_TAB [BATT_ROWS][TABLE_ENTRIES] = '{
    '{'{17'sd5500, 17'sd5000, 7'd16, 7'd50}, '{17'sd6000, 17'sd5500, 7'd1, 7'd50}},
    '{'{17'sd4000, 17'sd3500, 7'd16, 7'd50}, '{17'sd5000, 17'sd4500, 7'd1, 7'd50}}
  };

  localparam limit_t AC_TAB [AC_ROWS][TABLE_ENTRIES] = '{
    '{'{17'sd2310, 17'sd1960, 7'd16, 7'd80}, '{17'sd2560, 17'sd2210, 7'd1, 7'd80}},
    '{'{17'sd2310, 17'sd1960, 7'd16, 7'd80}, '{17'sd2560, 17'sd2210, 7'd1, 7'd80}},
    '{'{17'sd3330, 17'sd2980, 7'd16, 7'd80}, '{17'sd3590, 17'sd3240, 7'd1, 7'd80}},
    '{'{17'sd4620, 17'sd4270, 7'd16, 7'd80}, '{17'sd4870, 17'sd4520, 7'd1, 7'd80}}
  };

  // highest rating wins, so later matches override
  function automatic adapter_t classify(logic ac, logic [MV_W-1:0] mv);
    adapter_t kind;
    kind = ADP_UNKNOWN;
    if (ac) begin
      for (int k = 1; k < 4; k++) begin
        if (mv >= ID_LO[k] && mv <= ID_HI[k]) begin
          kind = adapter_t'(k[1:0]);
        end
      end
    end
    return kind;
  endfunction

  function automatic watch_t watch(logic signed [CUR_W-1:0] cur, limit_t lim, ent_t e);
    watch_t           w;
    logic [CNT_W-1:0] inc;
    w.ent = e;
    w.set = 1'b0;
    w.clr = 1'b0;
    inc   = e.cnt + 7'd1;
    if (e.trig) begin
      if (cur < lim.lo) begin
        if (inc >= lim.lo_cnt) begin
          w.clr = 1'b1;
          w.ent = '0;
        end else begin
          w.ent.cnt = inc;
        end
      end else begin
        w.ent.cnt = '0;
      end
    end else begin
      if (cur > lim.hi) begin
        if (inc >= lim.hi_cnt) begin
          w.set      = 1'b1;
          w.ent.trig = 1'b1;
          w.ent.cnt  = '0;
        end else begin
          w.ent.cnt = inc;
        end
      end else begin
        w.ent.cnt = '0;
      end
    end
    return w;
  endfunction

endpackage

[rtl/pltm_in_if.sv]
`timescale 1ns / 1ps

interface pltm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] batt_current;
  logic signed [15:0] charger_current;
  logic               ac_present;
  logic               ap_off;
  logic [11:0]        id_voltage_mv;

  modport source (
    output valid, mode, batt_current, charger_current, ac_present, ap_off,
           id_voltage_mv,
    input  ready
  );

  modport sink (
    input  valid, mode, batt_current, charger_current, ac_present, ap_off,
           id_voltage_mv,
    output ready
  );
endinterface

[rtl/pltm_out_if.sv]
`timescale 1ns / 1ps

interface pltm_out_if;
  logic        valid;
  logic        ready;
  logic        throttle_active;
  logic [3:0]  reason_bits;
  logic [1:0]  adapter_kind;
  logic        set_current_valid;
  logic [12:0] input_limit_ma;

  modport source (
    output valid, throttle_active, reason_bits, adapter_kind, set_current_valid,
           input_limit_ma,
    input  ready
  );

  modport sink (
    input  valid, throttle_active, reason_bits, adapter_kind, set_current_valid,
           input_limit_ma,
    output ready
  );
endinterface

[rtl/power_limit_throttle_monitor.sv]
// A request passes through the request stage, then the output register.
// Throughput: one request per cycle unless the output stalls; each threshold row
// is read on acceptance and written back as its request advances, with the last
// write forwarded to a same-row read. Reset (rst_n low, synchronous): adapter,
// reason bits, row valid bits and handshake state clear at once; rows never
// written read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module power_limit_throttle_monitor import pltm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pltm_in_if.sink               in_chan,
  pltm_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int BA_W = $clog2(BATT_ROWS);
  localparam int AA_W = $clog2(AC_ROWS);
  localparam int ROW_W = $bits(row_t);

  logic                 batt_sel;
  adapter_t             adapter_r;
  adapter_t             adapter_nxt;
  logic                 in_fire;
  logic                 out_free;
  logic                 s1_go;

  logic                 s1_valid_r;
  s1_req_t              s1_req_r;
  logic                 s1_bval_r;
  logic                 s1_aval_r;

  logic [BATT_ROWS-1:0] brow_valid_r;
  logic [AC_ROWS-1:0]   arow_valid_r;

  logic                 blw_valid_r;
  logic [BA_W-1:0]      blw_addr_r;
  row_t                 blw_data_r;
  logic                 alw_valid_r;
  logic [AA_W-1:0]      alw_addr_r;
  row_t                 alw_data_r;

  logic [ROW_W-1:0]     b_rdata;
  logic [ROW_W-1:0]     a_rdata;
  row_t                 brow_eff;
  row_t                 arow_eff;
  upd_t                 upd;
  logic                 b_we;
  logic                 a_we;

  logic [REASON_W-1:0]  reason_r;
  logic                 out_valid_r;
  logic                 out_setv_r;
  adapter_t             out_adapter_r;

  pltm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .batt_sel (batt_sel)
  );

  assign out_free       = !out_valid_r || out_chan.ready;
  assign s1_go          = s1_valid_r && out_free;
  assign in_chan.ready  = !s1_valid_r || out_free;
  assign in_fire        = in_chan.valid && in_chan.ready;

  assign adapter_nxt = (in_chan.mode == MODE_ADAPTER) ?
                       classify(in_chan.ac_present, in_chan.id_voltage_mv) : adapter_r;

  pltm_ram #(.WIDTH(ROW_W), .DEPTH(BATT_ROWS)) u_batt_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (s1_req_r.sel),
    .wdata (upd.brow),
    .re    (in_fire),
    .raddr (batt_sel),
    .rdata (b_rdata)
  );

  pltm_ram #(.WIDTH(ROW_W), .DEPTH(AC_ROWS)) u_ac_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (s1_req_r.adapter),
    .wdata (upd.arow),
    .re    (in_fire),
    .raddr (adapter_r),
    .rdata (a_rdata)
  );

  // forward the most recent write; unwritten rows read as zero
  always_comb begin
    if (blw_valid_r && blw_addr_r == s1_req_r.sel) begin
      brow_eff = blw_data_r;
    end else begin
      brow_eff = s1_bval_r ? row_t'(b_rdata) : '0;
    end
    if (alw_valid_r && alw_addr_r == s1_req_r.adapter) begin
      arow_eff = alw_data_r;
    end else begin
      arow_eff = s1_aval_r ? row_t'(a_rdata) : '0;
    end
  end

  pltm_update u_update (
    .req      (s1_req_r),
    .reason_i (reason_r),
    .brow_i   (brow_eff),
    .arow_i   (arow_eff),
    .upd      (upd)
  );

  assign b_we = s1_go && upd.bwe;
  assign a_we = s1_go && upd.awe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapter_r    <= ADP_UNKNOWN;
      s1_valid_r   <= 1'b0;
      brow_valid_r <= '0;
      arow_valid_r <= '0;
      blw_valid_r  <= 1'b0;
      alw_valid_r  <= 1'b0;
      reason_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        adapter_r <= adapter_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (b_we) begin
        brow_valid_r[s1_req_r.sel] <= 1'b1;
        blw_valid_r                <= 1'b1;
      end
      if (a_we) begin
        arow_valid_r[s1_req_r.adapter] <= 1'b1;
        alw_valid_r                    <= 1'b1;
      end
      if (s1_go) begin
        reason_r    <= upd.reason;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.mode    <= in_chan.mode;
      s1_req_r.batt    <= in_chan.batt_current;
      s1_req_r.chg     <= in_chan.charger_current;
      s1_req_r.ac      <= in_chan.ac_present;
      s1_req_r.apoff   <= in_chan.ap_off;
      s1_req_r.adapter <= adapter_nxt;
      s1_req_r.sel     <= batt_sel;
      s1_bval_r        <= brow_valid_r[batt_sel];
      s1_aval_r        <= arow_valid_r[adapter_r];
    end
    if (b_we) begin
      blw_addr_r <= s1_req_r.sel;
      blw_data_r <= upd.brow;
    end
    if (a_we) begin
      alw_addr_r <= s1_req_r.adapter;
      alw_data_r <= upd.arow;
    end
    if (s1_go) begin
      out_setv_r    <= (s1_req_r.mode == MODE_SAMPLE) && s1_req_r.ac;
      out_adapter_r <= s1_req_r.adapter;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.throttle_active   = |reason_r;
  assign out_chan.reason_bits       = reason_r;
  assign out_chan.adapter_kind      = out_adapter_r;
  assign out_chan.set_current_valid = out_setv_r;
  assign out_chan.input_limit_ma    = INPUT_LIMIT[out_adapter_r];

  a_write_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (b_we || a_we) |-> (s1_valid_r && out_free && s1_req_r.mode == MODE_SAMPLE))
    else $error("threshold row written without an advancing sample");

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || s1_go))
    else $error("request accepted over a stalled stage");

  a_reason_clear : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (reason_r == '0 && adapter_r == ADP_UNKNOWN))
    else $error("state not cleared by reset");

  a_adapter_event_keeps_reason : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_req_r.mode == MODE_ADAPTER) |=> (reason_r == $past(reason_r)))
    else $error("adapter event changed reason bits");

endmodule

[rtl/pltm_ram.sv]
`timescale 1ns / 1ps

module pltm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pltm_cfg.sv]
`timescale 1ns / 1ps

module pltm_cfg import pltm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  batt_sel
);

  logic batt_sel_r;
  logic hit;

  assign hit    = (paddr[2] == REG_BATT_SEL);
  assign pready = 1'b1;
  assign prdata = hit ? {{(CFG_DATA_W-1){1'b0}}, batt_sel_r} : '0;
  assign batt_sel = batt_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batt_sel_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && hit) begin
      batt_sel_r <= pwdata[0];
    end
  end

endmodule

[rtl/pltm_update.sv]
`timescale 1ns / 1ps

module pltm_update import pltm_pkg::*; (
  input  s1_req_t             req,
  input  logic [REASON_W-1:0] reason_i,
  input  row_t                brow_i,
  input  row_t                arow_i,
  output upd_t                upd
);

  logic signed [CUR_W-1:0] cur_b;
  logic signed [CUR_W-1:0] cur_c;
  watch_t                  wb [NB];
  watch_t                  wa [NA];

  // negate at full width so the most negative reading stays positive
  assign cur_b = -$signed({req.batt[15], req.batt});
  assign cur_c = $signed({req.chg[15], req.chg});

  always_comb begin
    upd.bwe    = (req.mode == MODE_SAMPLE);
    upd.awe    = (req.mode == MODE_SAMPLE) && !req.apoff;
    upd.reason = reason_i;
    upd.brow   = brow_i;
    upd.arow   = arow_i;
    for (int i = 0; i < NB; i++) begin
      wb[i] = watch(cur_b, BATT_TAB[req.sel][i], brow_i[i]);
    end
    for (int i = 0; i < NA; i++) begin
      wa[i] = watch(cur_c, AC_TAB[req.adapter][i], arow_i[i]);
    end
    if (upd.bwe) begin
      for (int i = 0; i < NB; i++) begin
        upd.brow[i] = wb[i].ent;
        if (wb[i].set) begin
          upd.reason[i] = 1'b1;
        end
        if (wb[i].clr) begin
          upd.reason[i] = 1'b0;
        end
      end
    end
    if (upd.awe) begin
      for (int i = 0; i < NA; i++) begin
        upd.arow[i] = wa[i].ent;
        if (wa[i].set) begin
          upd.reason[i + NB] = 1'b1;
        end
        if (wa[i].clr) begin
          upd.reason[i + NB] = 1'b0;
        end
      end
    end
  end

endmodule

[tb/power_limit_throttle_monitor_tb.sv]
`timescale 1ns / 1ps

module power_limit_throttle_monitor_tb import pltm_pkg::*; ();

  typedef struct packed {
    logic               mode;
    logic signed [15:0] batt;
    logic signed [15:0] chg;
    logic               ac;
    logic               apoff;
    logic [11:0]        mv;
  } pwr_req_t;

  typedef struct packed {
    logic        throttle;
    logic [3:0]  reason;
    adapter_t    kind;
    logic        set_valid;
    logic [12:0] limit_ma;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pltm_in_if  in_if ();
  pltm_out_if out_if ();

  power_limit_throttle_monitor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // predicted block state: {triggered, persistence count} per table entry
  logic [7:0] batt_state [4];
  logic [7:0] chg_state [8];
  logic [3:0] reason_now;
  adapter_t   adapter_now;
  logic       batt_sel_now;

  status_t expected_status_q [$];
  int      in_idle_pct    = 0;
  int      out_idle_pct   = 0;
  int      mismatch_count = 0;

  function automatic int batt_hi(logic sel, int e);
    if (sel) return (e == 0) ? 4000 : 5000;
    return (e == 0) ? 5500 : 6000;
  endfunction

  function automatic int batt_lo(logic sel, int e);
    if (sel) return (e == 0) ? 3500 : 4500;
    return (e == 0) ? 5000 : 5500;
  endfunction

  function automatic int chg_hi(adapter_t a, int e);
    case (a)
      ADP_65W: return (e == 0) ? 3330 : 3590;
      ADP_90W: return (e == 0) ? 4620 : 4870;
      default: return (e == 0) ? 2310 : 2560;
    endcase
  endfunction

  function automatic int chg_lo(adapter_t a, int e);
    case (a)
      ADP_65W: return (e == 0) ? 2980 : 3240;
      ADP_90W: return (e == 0) ? 4270 : 4520;
      default: return (e == 0) ? 1960 : 2210;
    endcase
  endfunction

  // advance one hysteresis entry; the triggered flag flips once its count is reached
  function automatic logic [7:0] persist(int cur, int hi, int lo, int hi_n, int lo_n,
                                         logic [7:0] st);
    logic       trig;
    logic [6:0] cnt;
    trig = st[7];
    cnt  = st[6:0];
    if (trig ? (cur < lo) : (cur > hi)) begin
      cnt = cnt + 7'd1;
      if (int'(cnt) >= (trig ? lo_n : hi_n)) begin
        trig = ~trig;
        cnt  = '0;
      end
    end else begin
      cnt = '0;
    end
    return {trig, cnt};
  endfunction

  function automatic status_t predict_status(pwr_req_t r);
    status_t    s;
    int         idx;
    logic [7:0] nxt;
    if (r.mode == MODE_ADAPTER) begin
      adapter_now = ADP_UNKNOWN;
      if (r.ac) begin
        if (r.mv >= 12'd725 && r.mv <= 12'd925) adapter_now = ADP_90W;
        else if (r.mv >= 12'd561 && r.mv <= 12'd717) adapter_now = ADP_65W;
        else if (r.mv >= 12'd434 && r.mv <= 12'd554) adapter_now = ADP_45W;
      end
    end else begin
      // battery side watches discharge, so negate at full precision
      for (int e = 0; e < 2; e++) begin
        idx = int'(batt_sel_now) * 2 + e;
        nxt = persist(-int'(r.batt), batt_hi(batt_sel_now, e), batt_lo(batt_sel_now, e),
                      (e == 0) ? 16 : 1, 50, batt_state[idx]);
        if (nxt[7] != batt_state[idx][7]) reason_now[e] = nxt[7];
        batt_state[idx] = nxt;
      end
      if (!r.apoff) begin
        for (int e = 0; e < 2; e++) begin
          idx = int'(adapter_now) * 2 + e;
          nxt = persist(int'(r.chg), chg_hi(adapter_now, e), chg_lo(adapter_now, e),
                        (e == 0) ? 16 : 1, 80, chg_state[idx]);
          if (nxt[7] != chg_state[idx][7]) reason_now[e + 2] = nxt[7];
          chg_state[idx] = nxt;
        end
      end
    end
    s.throttle  = |reason_now;
    s.reason    = reason_now;
    s.kind      = adapter_now;
    s.set_valid = (r.mode == MODE_SAMPLE) && r.ac;
    s.limit_ma  = (adapter_now == ADP_90W) ? 13'h1100 :
                  (adapter_now == ADP_65W) ? 13'h0c00 : 13'h0800;
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_status_q.push_back(predict_status(pwr_req_t'({in_if.mode,
        in_if.batt_current, in_if.charger_current, in_if.ac_present, in_if.ap_off,
        in_if.id_voltage_mv})));
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("result arrived with no request pending");
        mismatch_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_if.throttle_active !== want.throttle) begin
          $error("throttle_active: expected %0d, got %0d", want.throttle,
                 out_if.throttle_active);
          mismatch_count++;
        end
        if (out_if.reason_bits !== want.reason) begin
          $error("reason_bits: expected %0h, got %0h", want.reason, out_if.reason_bits);
          mismatch_count++;
        end
        if (out_if.adapter_kind !== want.kind) begin
          $error("adapter_kind: expected %0d, got %0d", want.kind, out_if.adapter_kind);
          mismatch_count++;
        end
        if (out_if.set_current_valid !== want.set_valid) begin
          $error("set_current_valid: expected %0d, got %0d", want.set_valid,
                 out_if.set_current_valid);
          mismatch_count++;
        end
        if (out_if.input_limit_ma !== want.limit_ma) begin
          $error("input_limit_ma: expected %0h, got %0h", want.limit_ma,
                 out_if.input_limit_ma);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_req(pwr_req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= r.mode;
    in_if.batt_current    <= r.batt;
    in_if.charger_current <= r.chg;
    in_if.ac_present      <= r.ac;
    in_if.ap_off          <= r.apoff;
    in_if.id_voltage_mv   <= r.mv;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the table select, then read it back
  task automatic write_table_select(logic sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BATT_SEL, 2'b00};
    pwdata  <= {31'b0, sel};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {31'b0, sel}) begin
      $error("battery_table_select: expected %0h, got %0h", {31'b0, sel}, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    batt_sel_now = sel;
  endtask

  task automatic test_adapter_windows();
    pwr_req_t    r;
    logic [11:0] probe [14];
    probe = '{12'd0, 12'd433, 12'd434, 12'd554, 12'd555, 12'd560, 12'd561,
              12'd717, 12'd718, 12'd724, 12'd725, 12'd925, 12'd926, 12'd4095};
    r = '0;
    r.mode = MODE_ADAPTER;
    r.ac   = 1'b1;
    foreach (probe[i]) begin
      r.mv = probe[i];
      send_req(r);
    end
    // no AC: unknown even inside the 90 W window
    r.ac = 1'b0;
    r.mv = 12'd800;
    send_req(r);
  endtask

  task automatic test_current_extremes();
    pwr_req_t r;
    r = '0;
    r.mode = MODE_SAMPLE;
    r.ac   = 1'b1;
    r.batt = 16'sh8000;
    r.chg  = 16'sh7fff;
    send_req(r);
    r.ac   = 1'b0;
    r.batt = 16'sh7fff;
    r.chg  = 16'sh8000;
    send_req(r);
    r.ac    = 1'b1;
    r.apoff = 1'b1;
    r.batt  = 16'sh0000;
    r.chg   = 16'sh7fff;
    send_req(r);
    r.mode  = MODE_ADAPTER;
    r.apoff = 1'b0;
    r.mv    = 12'd800;
    send_req(r);
    r.mode = MODE_SAMPLE;
    r.chg  = 16'sd4871;
    send_req(r);
    r.chg  = 16'sd0;
    send_req(r);
  endtask

  function automatic int level_pick(int hi, int lo, int cls);
    case (cls)
      0: return lo - 1 - int'($urandom_range(9000));
      1: return int'($urandom_range(hi, lo));
      2: return hi + 1 + int'($urandom_range(2500));
      default: begin
        case ($urandom_range(3))
          0: return lo - 1;
          1: return lo;
          2: return hi;
          default: return hi + 1;
        endcase
      end
    endcase
  endfunction

  // runs of samples that hold a level, some long enough to trip or release entries, mixed with adapter events
  task automatic test_random_sequences(int n_req);
    pwr_req_t r;
    int       sent;
    int       run_len;
    int       e_batt;
    int       e_chg;
    int       cls_batt;
    int       cls_chg;
    logic     run_ac;
    logic     run_apoff;
    sent = 0;
    while (sent < n_req) begin
      if ($urandom_range(99) < 8) begin
        r.mode  = MODE_ADAPTER;
        r.ac    = ($urandom_range(9) != 0);
        r.apoff = 1'($urandom_range(1));
        r.batt  = 16'($urandom_range(65535));
        r.chg   = 16'($urandom_range(65535));
        case ($urandom_range(3))
          0: r.mv = 12'($urandom_range(554, 434));
          1: r.mv = 12'($urandom_range(717, 561));
          2: r.mv = 12'($urandom_range(925, 725));
          default: r.mv = 12'($urandom_range(4095));
        endcase
        send_req(r);
        sent++;
      end else begin
        run_len   = ($urandom_range(9) < 6) ? $urandom_range(24, 1) : $urandom_range(100, 40);
        run_ac    = ($urandom_range(9) != 0);
        run_apoff = ($urandom_range(9) == 0);
        e_batt    = $urandom_range(1);
        e_chg     = $urandom_range(1);
        cls_batt  = $urandom_range(3);
        cls_chg   = $urandom_range(3);
        for (int k = 0; k < run_len && sent < n_req; k++) begin
          r.mode = MODE_SAMPLE;
          r.mv   = 12'($urandom_range(4095));
          if ($urandom_range(24) == 0) begin
            r.ac    = 1'($urandom_range(1));
            r.apoff = 1'($urandom_range(1));
            r.batt  = 16'($urandom_range(65535));
            r.chg   = 16'($urandom_range(65535));
          end else begin
            r.ac    = run_ac;
            r.apoff = run_apoff;
            r.batt  = 16'(-level_pick(batt_hi(batt_sel_now, e_batt),
                                      batt_lo(batt_sel_now, e_batt), cls_batt));
            r.chg   = 16'(level_pick(chg_hi(adapter_now, e_chg), chg_lo(adapter_now, e_chg),
                                     cls_chg));
          end
          send_req(r);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_if.valid           <= 1'b0;
    in_if.mode            <= MODE_SAMPLE;
    in_if.batt_current    <= '0;
    in_if.charger_current <= '0;
    in_if.ac_present      <= 1'b0;
    in_if.ap_off          <= 1'b0;
    in_if.id_voltage_mv   <= '0;
    for (int i = 0; i < 4; i++) batt_state[i] = '0;
    for (int i = 0; i < 8; i++) chg_state[i] = '0;
    reason_now   = '0;
    adapter_now  = ADP_UNKNOWN;
    batt_sel_now = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 17;
    out_idle_pct = 60;
    write_table_select(1'b0);
    test_adapter_windows();
    test_current_extremes();
    test_random_sequences(540);
    drain_results();

    in_idle_pct  = 60;
    out_idle_pct = 17;
    write_table_select(1'b1);
    test_random_sequences(570);
    drain_results();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_table_select(1'b0);
    test_random_sequences(290);
    drain_results();
    write_table_select(1'b1);
    test_random_sequences(290);
    drain_results();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/pltm_pkg.sv
rtl/pltm_in_if.sv
rtl/pltm_out_if.sv
rtl/pltm_ram.sv
rtl/pltm_cfg.sv
rtl/pltm_update.sv
rtl/power_limit_throttle_monitor.sv
tb/power_limit_throttle_monitor_tb.sv
